FILE: hdl/cwc_pkg.sv
// shared types, codes and constants for the card whitelist controller
package cwc_pkg;

    localparam int TABLE_SLOTS_DEF = 8;
    localparam int KEY_BYTES_DEF   = 5;

    localparam int CARD_KEY_W = 40;
    localparam int OP_W       = 3;
    localparam int SLOT_W     = 4;
    localparam int PERM_W     = 8;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 4;
    localparam int SIDX_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int WINDOW_W   = 16;
    localparam int TIMEOUT_W  = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [PERM_W-1:0] PERM_DOOR_BIT = 8'h01;
    localparam logic [PERM_W-1:0] PERM_BOLT_BIT = 8'h02;

    localparam logic [WINDOW_W-1:0]  WINDOW_RESET     = 16'd1000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 20'd30000;
    localparam logic [PERM_W-1:0]    ENROL_PERM_RESET = PERM_DOOR_BIT | PERM_BOLT_BIT;

    typedef enum logic [OP_W-1:0] {
        OP_SWIPE       = 3'd0,
        OP_DELETE      = 3'd1,
        OP_SET_PERM    = 3'd2,
        OP_START_ENROL = 3'd3,
        OP_STOP_ENROL  = 3'd4,
        OP_TICK        = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NONE        = 4'd0,
        STAT_GRANTED     = 4'd1,
        STAT_DENIED      = 4'd2,
        STAT_BAD_CHECK   = 4'd3,
        STAT_REPEAT      = 4'd4,
        STAT_ADDED       = 4'd5,
        STAT_ADD_FAIL    = 4'd6,
        STAT_TIMEOUT     = 4'd7,
        STAT_DELETED     = 4'd8,
        STAT_DEL_FAIL    = 4'd9,
        STAT_PERM_SET    = 4'd10,
        STAT_PERM_FAIL   = 4'd11,
        STAT_MODE_CHANGE = 4'd12
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CHECKSUM_REQ = 2'd0,
        CFG_REPEAT_WIN   = 2'd1,
        CFG_ENROL_TMO    = 2'd2,
        CFG_ENROL_PERM   = 2'd3
    } cfg_idx_t;

    // flags returned by the shared compare unit
    typedef struct packed {
        logic key_eq;
        logic over;
        logic under;
    } cmp_res_t;

endpackage

FILE: hdl/cwc_ram.sv
// generic single-write, single-read ram with registered read data
module cwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/cwc_cmp.sv
// shared compare unit: key equality and elapsed-time window checks
module cwc_cmp import cwc_pkg::*; #(
    parameter int KEY_W = 40
) (
    input  logic [KEY_W-1:0]  key_a,
    input  logic [KEY_W-1:0]  key_b,
    input  logic [TIME_W-1:0] t_now,
    input  logic [TIME_W-1:0] t_ref,
    input  logic [TIME_W-1:0] t_lim,
    output cmp_res_t          res
);

    logic [TIME_W-1:0] t_diff;

    // elapsed time wraps modulo 2^32
    assign t_diff     = t_now - t_ref;
    assign res.key_eq = (key_a == key_b);
    assign res.over   = (t_diff > t_lim);
    assign res.under  = (t_diff < t_lim);

endmodule

FILE: hdl/card_whitelist_controller.sv
// commands, and swipes stopped by checksum or repeat, pass through ST_TMO and ST_OP to
// ST_DONE; swipes that reach the table also pass through ST_SWEEP and ST_FIN
// one item at a time: a new item is taken only back in ST_IDLE; a swipe that reaches the
// table sweeps the slots through the key ram read port, one slot per cycle
// the next item is taken while a result still waits on the output
// reset (aresetn low, synchronous) empties the table, leaves enrol mode, clears the
// repeat state and loads the register defaults; no clearing pass is needed
module card_whitelist_controller import cwc_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [CARD_KEY_W-1:0] s_card_key,
    input  logic [SLOT_W-1:0]     s_slot,
    input  logic [PERM_W-1:0]     s_new_permission,
    input  logic [TIME_W-1:0]     s_now_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PERM_W-1:0]     m_permission,
    output logic [SIDX_W-1:0]     m_slot_index,
    output logic [COUNT_W-1:0]    m_card_count,
    output logic                  m_enrol_mode
);

    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int IDX_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
    localparam int SLOT_CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TMO,
        ST_OP,
        ST_SWEEP,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic                 chk_req_reg;
    logic [WINDOW_W-1:0]  window_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [PERM_W-1:0]    enrol_perm_reg;

    // item payload
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PERM_W-1:0] newp_reg;
    logic [TIME_W-1:0] now_reg;

    // block state
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   enrol_reg;
    logic [KEY_W-1:0]       last_card_reg;
    logic [TIME_W-1:0]      last_time_reg;
    logic [TIME_W-1:0]      idle_start_reg;
    logic                   timed_reg;

    // sweep
    logic [IDX_W-1:0]  idx_reg;
    logic              iss_reg;
    logic              cmp_live_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [PERM_W-1:0] hit_perm_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  empty_idx_reg;

    // result held until the output register is free
    status_t           res_status_reg;
    logic [PERM_W-1:0] res_perm_reg;
    logic [IDX_W-1:0]  res_sidx_reg;

    // output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [PERM_W-1:0]   m_perm_reg;
    logic [SIDX_W-1:0]   m_sidx_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic                m_enrol_reg;

    logic [63:0]            key_full;
    logic [KEY_W-1:0]       key_in;
    logic [7:0]             xor_acc;
    logic                   check_ok;
    logic [SLOT_CMP_W-1:0]  slot_wide;
    logic                   slot_in_range;
    logic                   slot_is_all;
    logic [IDX_W-1:0]       slot_idx;
    logic                   slot_used;
    logic [KEY_W-1:0]       cmp_key_b;
    logic [TIME_W-1:0]      cmp_t_ref;
    logic [TIME_W-1:0]      cmp_t_lim;
    cmp_res_t               cmp;
    logic                   tmo_hit;
    logic                   is_repeat;
    logic                   swipe_go;
    logic [KEY_W-1:0]       key_rd;
    logic [PERM_W-1:0]      perm_rd;
    logic                   fin_add;
    logic                   fin_grant;
    logic                   set_perm_ok;
    logic                   key_we;
    logic                   perm_we;
    logic [IDX_W-1:0]       perm_waddr;
    logic [PERM_W-1:0]      perm_wdata;
    logic                   last_idx;
    logic                   cmp_valid;
    logic                   out_load;

    // key masked or widened to the table key width
    assign key_full = {{(64 - CARD_KEY_W){1'b0}}, s_card_key};
    assign key_in   = key_full[KEY_W-1:0];

    always_comb begin
        xor_acc = '0;
        for (int i = 0; i < KEY_BYTES - 1; i++) begin
            xor_acc = xor_acc ^ key_reg[8*i +: 8];
        end
    end
    assign check_ok = (xor_acc == key_reg[KEY_W-1 -: 8]);

    assign slot_wide     = SLOT_CMP_W'(slot_reg);
    assign slot_in_range = (slot_wide < SLOT_CMP_W'(TABLE_SLOTS));
    assign slot_is_all   = (slot_wide == SLOT_CMP_W'(TABLE_SLOTS));
    assign slot_idx      = slot_wide[IDX_W-1:0];
    assign slot_used     = slot_in_range && valid_reg[slot_idx];

    // operand selection for the shared compare unit
    assign cmp_key_b = (state_reg == ST_SWEEP) ? key_rd : last_card_reg;
    assign cmp_t_ref = (state_reg == ST_TMO) ? idle_start_reg : last_time_reg;
    assign cmp_t_lim = (state_reg == ST_TMO) ? TIME_W'(timeout_reg) : TIME_W'(window_reg);

    cwc_cmp #(
        .KEY_W (KEY_W)
    ) u_cmp (
        .key_a (key_reg),
        .key_b (cmp_key_b),
        .t_now (now_reg),
        .t_ref (cmp_t_ref),
        .t_lim (cmp_t_lim),
        .res   (cmp)
    );

    assign tmo_hit   = enrol_reg && cmp.over;
    assign is_repeat = cmp.key_eq && cmp.under;
    assign swipe_go  = (op_reg == OP_SWIPE) && !(chk_req_reg && !check_ok) && !is_repeat;

    assign fin_add = (state_reg == ST_FIN) && enrol_reg && found_reg && !hit_reg &&
                     (count_reg < CNT_W'(TABLE_SLOTS)) && (enrol_perm_reg != '0);
    assign fin_grant   = !enrol_reg && hit_reg;
    assign set_perm_ok = (state_reg == ST_OP) && (op_reg == OP_SET_PERM) && slot_used &&
                         (newp_reg != '0);

    assign key_we     = fin_add;
    assign perm_we    = fin_add || set_perm_ok;
    assign perm_waddr = fin_add ? empty_idx_reg : slot_idx;
    assign perm_wdata = fin_add ? enrol_perm_reg : newp_reg;

    cwc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (empty_idx_reg),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (key_rd)
    );

    cwc_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_SLOTS)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (idx_reg),
        .rdata (perm_rd)
    );

    assign last_idx  = (cmp_idx_reg == IDX_W'(TABLE_SLOTS - 1));
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_req_reg    <= 1'b0;
            window_reg     <= WINDOW_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            enrol_perm_reg <= ENROL_PERM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_CHECKSUM_REQ: chk_req_reg    <= cfg_wdata[0];
                CFG_REPEAT_WIN:   window_reg     <= cfg_wdata[WINDOW_W-1:0];
                CFG_ENROL_TMO:    timeout_reg    <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_ENROL_PERM:   enrol_perm_reg <= cfg_wdata[PERM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            enrol_reg      <= 1'b0;
            last_card_reg  <= '0;
            last_time_reg  <= '0;
            idle_start_reg <= '0;
            timed_reg      <= 1'b0;
            iss_reg        <= 1'b0;
            cmp_live_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_op;
                        key_reg   <= key_in;
                        slot_reg  <= s_slot;
                        newp_reg  <= s_new_permission;
                        now_reg   <= s_now_ms;
                        state_reg <= ST_TMO;
                    end
                end

                ST_TMO: begin
                    timed_reg <= tmo_hit;
                    if (tmo_hit) begin
                        enrol_reg      <= 1'b0;
                        idle_start_reg <= '0;
                    end
                    state_reg <= ST_OP;
                end

                ST_OP: begin
                    res_perm_reg <= '0;
                    res_sidx_reg <= ((op_reg == OP_DELETE && slot_used) || set_perm_ok) ?
                                    slot_idx : '0;
                    state_reg    <= swipe_go ? ST_SWEEP : ST_DONE;
                    unique case (op_t'(op_reg))
                        OP_SWIPE: begin
                            if (chk_req_reg && !check_ok) begin
                                res_status_reg <= STAT_BAD_CHECK;
                            end else if (is_repeat) begin
                                res_status_reg <= STAT_REPEAT;
                            end else begin
                                last_card_reg <= key_reg;
                                last_time_reg <= now_reg;
                                if (enrol_reg) begin
                                    idle_start_reg <= now_reg;
                                end
                                idx_reg      <= '0;
                                iss_reg      <= 1'b1;
                                cmp_live_reg <= 1'b0;
                                hit_reg      <= 1'b0;
                                hit_idx_reg  <= '0;
                                hit_perm_reg <= '0;
                                found_reg    <= 1'b0;
                            end
                        end
                        OP_DELETE: begin
                            if (slot_is_all) begin
                                valid_reg      <= '0;
                                count_reg      <= '0;
                                res_status_reg <= STAT_DELETED;
                            end else if (slot_used) begin
                                valid_reg[slot_idx] <= 1'b0;
                                if (count_reg != '0) begin
                                    count_reg <= count_reg - 1'b1;
                                end
                                res_status_reg <= STAT_DELETED;
                            end else begin
                                res_status_reg <= STAT_DEL_FAIL;
                            end
                        end
                        OP_SET_PERM: begin
                            if (set_perm_ok) begin
                                res_status_reg <= STAT_PERM_SET;
                            end else begin
                                res_status_reg <= STAT_PERM_FAIL;
                            end
                        end
                        OP_START_ENROL: begin
                            enrol_reg      <= 1'b1;
                            idle_start_reg <= now_reg;
                            res_status_reg <= STAT_MODE_CHANGE;
                        end
                        OP_STOP_ENROL: begin
                            enrol_reg      <= 1'b0;
                            res_status_reg <= STAT_MODE_CHANGE;
                        end
                        OP_TICK: begin
                            res_status_reg <= timed_reg ? STAT_TIMEOUT : STAT_NONE;
                        end
                        default: begin
                            res_status_reg <= STAT_NONE;
                        end
                    endcase
                end

                ST_SWEEP: begin
                    // address issue runs one slot ahead of the compare
                    if (iss_reg) begin
                        if (idx_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                            iss_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    cmp_live_reg <= iss_reg;
                    cmp_idx_reg  <= idx_reg;
                    if (cmp_live_reg) begin
                        if (cmp_valid && cmp.key_eq && !hit_reg) begin
                            hit_reg      <= 1'b1;
                            hit_idx_reg  <= cmp_idx_reg;
                            hit_perm_reg <= perm_rd;
                        end
                        if (!cmp_valid && !found_reg) begin
                            found_reg     <= 1'b1;
                            empty_idx_reg <= cmp_idx_reg;
                        end
                        if (last_idx) begin
                            state_reg <= ST_FIN;
                        end
                    end
                end

                ST_FIN: begin
                    res_perm_reg <= fin_grant ? hit_perm_reg : '0;
                    res_sidx_reg <= fin_grant ? hit_idx_reg : (fin_add ? empty_idx_reg : '0);
                    if (!enrol_reg) begin
                        if (hit_reg) begin
                            res_status_reg <= STAT_GRANTED;
                        end else begin
                            res_status_reg <= STAT_DENIED;
                        end
                    end else if (fin_add) begin
                        valid_reg[empty_idx_reg] <= 1'b1;
                        count_reg                <= count_reg + 1'b1;
                        res_status_reg           <= STAT_ADDED;
                    end else begin
                        res_status_reg <= STAT_ADD_FAIL;
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE: begin
                    if (out_load) begin
                        m_status_reg <= res_status_reg;
                        m_perm_reg   <= res_perm_reg;
                        m_sidx_reg   <= SIDX_W'(res_sidx_reg);
                        m_count_reg  <= COUNT_W'(count_reg);
                        m_enrol_reg  <= enrol_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_permission = m_perm_reg;
    assign m_slot_index = m_sidx_reg;
    assign m_card_count = m_count_reg;
    assign m_enrol_mode = m_enrol_reg;

`ifndef NO_ASSERTIONS
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("occupied count differs from occupied slots");

    a_no_write_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (!key_we && !perm_we))
        else $error("table written during lookup sweep");

    a_timeout_leaves_enrol: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TMO && tmo_hit) |=> (!enrol_reg && timed_reg))
        else $error("enrol timeout did not end enrol mode");
`endif

endmodule

FILE: verif/tb_top.sv
// self-checking bench for the card whitelist controller: predicted verdicts checked beat by beat
module tb_top;
    import cwc_pkg::*;

    localparam int N_SLOTS         = TABLE_SLOTS_DEF;
    localparam int N_REGS          = 4;
    localparam int POOL_SIZE       = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int DRAIN_PAD       = 2 * N_SLOTS + 20;
    localparam int LIMIT_CYCLES    = 400000;

    localparam logic [OP_W-1:0]   OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_7 = 3'd7;
    localparam logic [SLOT_W-1:0] SLOT_ALL   = SLOT_W'(N_SLOTS);

    typedef struct packed {
        status_t              status;
        logic [PERM_W-1:0]    perm;
        logic [SIDX_W-1:0]    slot_idx;
        logic [COUNT_W-1:0]   count;
        logic                 enrol;
    } verdict_t;

    class access_verdict_board;
        logic [CARD_KEY_W-1:0] key_tbl [N_SLOTS];
        logic [PERM_W-1:0]     perm_tbl [N_SLOTS];
        int unsigned           n_cards;
        bit                    enrolling;
        logic [CARD_KEY_W-1:0] last_key;
        logic [TIME_W-1:0]     last_ms;
        logic [TIME_W-1:0]     idle_from;
        bit                    need_xor;
        logic [WINDOW_W-1:0]   window;
        logic [TIMEOUT_W-1:0]  idle_limit;
        logic [PERM_W-1:0]     enrol_perm;
        verdict_t              expected[$];
        int                    errors;
        int                    beats;

        function new();
            foreach (key_tbl[i]) begin
                key_tbl[i]  = '0;
                perm_tbl[i] = '0;
            end
            n_cards    = 0;
            enrolling  = 1'b0;
            last_key   = '0;
            last_ms    = '0;
            idle_from  = '0;
            need_xor   = 1'b0;
            window     = WINDOW_RESET;
            idle_limit = TIMEOUT_RESET;
            enrol_perm = ENROL_PERM_RESET;
            errors     = 0;
            beats      = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CHECKSUM_REQ: need_xor   = val[0];
                CFG_REPEAT_WIN:   window     = val[WINDOW_W-1:0];
                CFG_ENROL_TMO:    idle_limit = val[TIMEOUT_W-1:0];
                CFG_ENROL_PERM:   enrol_perm = val[PERM_W-1:0];
                default: ;
            endcase
        endfunction

        // top key byte carries the xor of the four lower bytes
        function bit xor_ok(logic [CARD_KEY_W-1:0] key);
            return key[39:32] == (key[7:0] ^ key[15:8] ^ key[23:16] ^ key[31:24]);
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [CARD_KEY_W-1:0] key,
                                logic [SLOT_W-1:0] slot, logic [PERM_W-1:0] newp,
                                logic [TIME_W-1:0] now);
            verdict_t          v;
            logic [TIME_W-1:0] idle_ms;
            logic [TIME_W-1:0] since_last;
            bit                timed_out;
            bit                dup;
            bit                found;
            int                free_at;
            v         = '0;
            timed_out = 1'b0;
            idle_ms   = now - idle_from;
            if (enrolling && idle_ms > TIME_W'(idle_limit)) begin
                enrolling = 1'b0;
                idle_from = '0;
                timed_out = 1'b1;
            end
            case (op)
                OP_SWIPE: begin
                    since_last = now - last_ms;
                    if (need_xor && !xor_ok(key)) begin
                        v.status = STAT_BAD_CHECK;
                    end else if (key == last_key && since_last < TIME_W'(window)) begin
                        v.status = STAT_REPEAT;
                    end else begin
                        last_key = key;
                        last_ms  = now;
                        if (!enrolling) begin
                            v.status = STAT_DENIED;
                            for (int i = 0; i < N_SLOTS; i++) begin
                                if (perm_tbl[i] != 0 && key_tbl[i] == key) begin
                                    v.status   = STAT_GRANTED;
                                    v.perm     = perm_tbl[i];
                                    v.slot_idx = SIDX_W'(i);
                                    break;
                                end
                            end
                        end else begin
                            idle_from = now;
                            dup       = 1'b0;
                            found     = 1'b0;
                            free_at   = 0;
                            for (int i = 0; i < N_SLOTS; i++) begin
                                if (perm_tbl[i] != 0) begin
                                    if (key_tbl[i] == key)
                                        dup = 1'b1;
                                end else if (!found) begin
                                    found   = 1'b1;
                                    free_at = i;
                                end
                            end
                            if (dup || !found || n_cards >= N_SLOTS || enrol_perm == 0) begin
                                v.status = STAT_ADD_FAIL;
                            end else begin
                                key_tbl[free_at]  = key;
                                perm_tbl[free_at] = enrol_perm;
                                n_cards++;
                                v.status   = STAT_ADDED;
                                v.slot_idx = SIDX_W'(free_at);
                            end
                        end
                    end
                end
                OP_DELETE: begin
                    if (slot == SLOT_ALL) begin
                        foreach (key_tbl[i]) begin
                            key_tbl[i]  = '0;
                            perm_tbl[i] = '0;
                        end
                        n_cards  = 0;
                        v.status = STAT_DELETED;
                    end else if (slot < N_SLOTS && perm_tbl[slot[SIDX_W-1:0]] != 0) begin
                        key_tbl[slot[SIDX_W-1:0]]  = '0;
                        perm_tbl[slot[SIDX_W-1:0]] = '0;
                        if (n_cards > 0)
                            n_cards--;
                        v.status   = STAT_DELETED;
                        v.slot_idx = slot[SIDX_W-1:0];
                    end else begin
                        v.status = STAT_DEL_FAIL;
                    end
                end
                OP_SET_PERM: begin
                    if (slot < N_SLOTS && perm_tbl[slot[SIDX_W-1:0]] != 0 && newp != 0) begin
                        perm_tbl[slot[SIDX_W-1:0]] = newp;
                        v.status   = STAT_PERM_SET;
                        v.slot_idx = slot[SIDX_W-1:0];
                    end else begin
                        v.status = STAT_PERM_FAIL;
                    end
                end
                OP_START_ENROL: begin
                    enrolling = 1'b1;
                    idle_from = now;
                    v.status  = STAT_MODE_CHANGE;
                end
                OP_STOP_ENROL: begin
                    enrolling = 1'b0;
                    v.status  = STAT_MODE_CHANGE;
                end
                OP_TICK: v.status = timed_out ? STAT_TIMEOUT : STAT_NONE;
                default: v.status = STAT_NONE;
            endcase
            v.count = COUNT_W'(n_cards);
            v.enrol = enrolling;
            expected.push_back(v);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] result beat %0d: %s", $time, beats, what);
        endtask

        task check_verdict(verdict_t got);
            verdict_t want;
            beats++;
            if (expected.size() == 0) begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.perm !== want.perm)
                report_mismatch($sformatf("permission %0h, expected %0h", got.perm, want.perm));
            if (got.slot_idx !== want.slot_idx)
                report_mismatch($sformatf("slot_index %0d, expected %0d",
                                          got.slot_idx, want.slot_idx));
            if (got.count !== want.count)
                report_mismatch($sformatf("card_count %0d, expected %0d", got.count, want.count));
            if (got.enrol !== want.enrol)
                report_mismatch($sformatf("enrol_mode %0b, expected %0b", got.enrol, want.enrol));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn          = 1'b0;
    logic                  cfg_we           = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr         = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata        = '0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op             = '0;
    logic [CARD_KEY_W-1:0] s_card_key       = '0;
    logic [SLOT_W-1:0]     s_slot           = '0;
    logic [PERM_W-1:0]     s_new_permission = '0;
    logic [TIME_W-1:0]     s_now_ms         = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [PERM_W-1:0]     m_permission;
    logic [SIDX_W-1:0]     m_slot_index;
    logic [COUNT_W-1:0]    m_card_count;
    logic                  m_enrol_mode;

    access_verdict_board   board;
    logic [CARD_KEY_W-1:0] key_pool [POOL_SIZE];
    logic [CARD_KEY_W-1:0] last_swiped  = '0;
    logic [TIME_W-1:0]     now_cur      = '0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    items_sent     = 0;
    int unsigned           cycle_count    = 0;

    card_whitelist_controller u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_card_key       (s_card_key),
        .s_slot           (s_slot),
        .s_new_permission (s_new_permission),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_permission     (m_permission),
        .m_slot_index     (m_slot_index),
        .m_card_count     (m_card_count),
        .m_enrol_mode     (m_enrol_mode)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_ready     <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_verdict(verdict_t'({m_status, m_permission, m_slot_index,
                                            m_card_count, m_enrol_mode}));
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [CARD_KEY_W-1:0] make_key(bit good);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        if (good)
            return {lo[7:0] ^ lo[15:8] ^ lo[23:16] ^ lo[31:24], lo};
        return {hi[7:0], lo};
    endfunction

    // mostly known cards so grants, duplicates and a full table all come up
    function automatic logic [CARD_KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 10) begin
            if (r < 75)
                last_swiped = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 90)
                last_swiped = make_key(1'b1);
            else
                last_swiped = make_key(1'b0);
        end
        return last_swiped;
    endfunction

    function automatic void advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            now_cur = now_cur;
        else if (r < 60)
            now_cur += $urandom_range(1, 500);
        else if (r < 85)
            now_cur += $urandom_range(501, 5000);
        else if (r < 93)
            now_cur += $urandom_range(5001, 70000);
        else if (r < 97)
            now_cur += $urandom_range(70001, 1200000);
        else
            now_cur += $urandom;
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [CARD_KEY_W-1:0] key,
                             logic [SLOT_W-1:0] slot, logic [PERM_W-1:0] newp,
                             logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_op             <= op;
        s_card_key       <= key;
        s_slot           <= slot;
        s_new_permission <= newp;
        s_now_ms         <= now;
        do @(posedge aclk); while (!s_ready);
        board.note_item(op, key, slot, newp, now);
        items_sent++;
    endtask

    // hold off until every beat is back, then give the block time to go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic program_regs(bit xor_req, logic [WINDOW_W-1:0] win,
                                logic [TIMEOUT_W-1:0] tmo, logic [PERM_W-1:0] eperm);
        logic [CFG_DATA_W-1:0] vals [N_REGS];
        vals[CFG_CHECKSUM_REQ] = CFG_DATA_W'(xor_req);
        vals[CFG_REPEAT_WIN]   = CFG_DATA_W'(win);
        vals[CFG_ENROL_TMO]    = CFG_DATA_W'(tmo);
        vals[CFG_ENROL_PERM]   = CFG_DATA_W'(eperm);
        for (int i = 0; i < N_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            board.set_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit xor_req,
                             logic [WINDOW_W-1:0] win, logic [TIMEOUT_W-1:0] tmo,
                             logic [PERM_W-1:0] eperm);
        int                    target;
        int                    r;
        int                    q;
        int                    n_swipes;
        logic [OP_W-1:0]       op;
        logic [SLOT_W-1:0]     slot;
        logic [PERM_W-1:0]     newp;
        logic [CARD_KEY_W-1:0] key;
        program_regs(xor_req, win, tmo, eperm);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + ITEMS_PER_PHASE;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                settle();
            end else if (r < 12) begin
                // enrol session: start, a few swipes close together, maybe stop
                advance_clock();
                send_item(OP_START_ENROL, make_key(1'b0), SLOT_W'($urandom_range(0, 15)),
                          PERM_W'($urandom_range(0, 255)), now_cur);
                n_swipes = $urandom_range(1, 6);
                repeat (n_swipes) begin
                    now_cur += $urandom_range(0, 400);
                    send_item(OP_SWIPE, pick_key(), SLOT_W'($urandom_range(0, 15)),
                              PERM_W'($urandom_range(0, 255)), now_cur);
                end
                if ($urandom_range(0, 1)) begin
                    advance_clock();
                    send_item(OP_STOP_ENROL, make_key(1'b0), SLOT_W'($urandom_range(0, 15)),
                              PERM_W'($urandom_range(0, 255)), now_cur);
                end
            end else begin
                advance_clock();
                r    = $urandom_range(0, 99);
                q    = $urandom_range(0, 99);
                slot = SLOT_W'($urandom_range(0, 15));
                newp = PERM_W'($urandom_range(0, 255));
                if (r < 50) begin
                    op = OP_SWIPE;
                end else if (r < 60) begin
                    op   = OP_DELETE;
                    slot = (q < 10) ? SLOT_ALL :
                           (q < 90) ? SLOT_W'($urandom_range(0, N_SLOTS - 1)) :
                                      SLOT_W'($urandom_range(N_SLOTS + 1, 15));
                end else if (r < 70) begin
                    op   = OP_SET_PERM;
                    slot = (q < 90) ? SLOT_W'($urandom_range(0, N_SLOTS - 1)) :
                                      SLOT_W'($urandom_range(N_SLOTS, 15));
                    newp = ($urandom_range(0, 9) == 0) ? '0 : PERM_W'($urandom_range(1, 255));
                end else if (r < 76) begin
                    op = OP_START_ENROL;
                end else if (r < 82) begin
                    op = OP_STOP_ENROL;
                end else if (r < 96) begin
                    op = OP_TICK;
                end else begin
                    op = q[0] ? OP_SPARE_6 : OP_SPARE_7;
                end
                key = (op == OP_SWIPE) ? pick_key() : make_key(1'b0);
                send_item(op, key, slot, newp, now_cur);
            end
        end
        settle();
    endtask

    initial begin
        board = new();
        foreach (key_pool[i])
            key_pool[i] = make_key(1'b1);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: repeat of the zero key at reset, grant, deny, enrol paths
        send_item(OP_SWIPE,       '0,          '0, '0, 32'd0);
        send_item(OP_SWIPE,       '1,          '0, '0, 32'd5);
        send_item(OP_START_ENROL, '0,          '0, '0, 32'd10);
        send_item(OP_SWIPE,       key_pool[0], '0, '0, 32'd20);
        send_item(OP_SWIPE,       key_pool[0], '0, '0, 32'd2000);
        send_item(OP_SWIPE,       '1,          '0, '0, 32'd2100);
        send_item(OP_TICK,        '0,          '0, '0, 32'd32101);
        send_item(OP_SWIPE,       key_pool[0], '0, '0, 32'd40000);
        send_item(OP_SET_PERM,    '0,          4'd1,  8'd0,   32'd40010);
        send_item(OP_SET_PERM,    '0,          4'd1,  8'd255, 32'd40020);
        send_item(OP_SET_PERM,    '0,          4'd5,  8'd7,   32'd40030);
        send_item(OP_SET_PERM,    '0,          4'd15, 8'd9,   32'd40040);
        send_item(OP_DELETE,      '0,          4'd0,  '0,     32'd40050);
        send_item(OP_DELETE,      '0,          4'd0,  '0,     32'd40060);
        send_item(OP_DELETE,      '1,          4'd15, '1,     32'd40070);
        send_item(OP_SWIPE,       '1,          '0, '0, 32'd50000);
        send_item(OP_SPARE_6,     '1,          '1, '1, 32'd50010);
        send_item(OP_SPARE_7,     '0,          '0, '0, 32'd50020);
        // idle time measured across the 32-bit wrap
        send_item(OP_START_ENROL, '0,          '0, '0, 32'hFFFF_FF00);
        send_item(OP_SWIPE,       key_pool[1], '0, '0, 32'h0000_0010);
        send_item(OP_STOP_ENROL,  '0,          '0, '0, 32'h0000_0020);
        // timeout seen by a swipe, which then runs in swipe mode
        send_item(OP_START_ENROL, '0,          '0, '0, 32'd100);
        send_item(OP_SWIPE,       key_pool[2], '0, '0, 32'd30101);
        settle();

        // checksum on, zero enrol permission makes every add fail
        program_regs(1'b1, WINDOW_RESET, TIMEOUT_RESET, '0);
        send_item(OP_START_ENROL, '0, '0, '0, 32'd200);
        send_item(OP_SWIPE, key_pool[3] ^ (40'd1 << 32), '0, '0, 32'd250);
        send_item(OP_SWIPE, key_pool[3], '0, '0, 32'd300);
        settle();

        // fill the table until an add fails on a full table, then clear it all
        program_regs(1'b1, WINDOW_RESET, TIMEOUT_RESET, 8'd255);
        send_item(OP_START_ENROL, '0, '0, '0, 32'd5000);
        for (int j = 3; j < POOL_SIZE; j++)
            send_item(OP_SWIPE, key_pool[j], '0, '0, 32'(5000 + 10 * j));
        send_item(OP_DELETE, '0, SLOT_ALL, '0, 32'd5200);
        send_item(OP_STOP_ENROL, '0, '0, '0, 32'd5210);
        settle();

        now_cur = 32'd100000;
        run_phase(0, 0, 1'b0, '0, '0, 8'd255);
        run_phase(88, 0, 1'b1, '1, '1, 8'd1);
        run_phase(0, 88, 1'b0, WINDOW_W'($urandom_range(1, 3000)),
                  TIMEOUT_W'($urandom_range(50, 5000)), PERM_W'($urandom_range(1, 255)));
        run_phase(24, 24, 1'b1, 16'd200, 20'd2000, PERM_W'($urandom_range(1, 255)));

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
